>>> rtl/tga_psd_pkg.sv
// ---------------------------------------------------------------------------
// TGA pixel stream decoder package
// Shared constants, phase type, divider interface structs and pixel helpers.
// ---------------------------------------------------------------------------
package tga_psd_pkg;

    // Colormap storage depth and address width.
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

    // Width of the row and column counters.
    localparam int COORD_BITS = 16;

    // Column plus run length, and the width of the pixel count.
    localparam int SUM_W   = COORD_BITS + 1;
    localparam int TOTAL_W = 2 * COORD_BITS;

    // Row advance of one run never exceeds 128, so eight quotient bits.
    localparam int QUOT_W = 8;

    // Configuration register indexes.
    localparam logic [2:0] CFG_IMAGE_KIND      = 3'd0;
    localparam logic [2:0] CFG_BYTES_PER_PIXEL = 3'd1;
    localparam logic [2:0] CFG_IMAGE_WIDTH     = 3'd2;
    localparam logic [2:0] CFG_IMAGE_HEIGHT    = 3'd3;
    localparam logic [2:0] CFG_PALETTE_ENTRIES = 3'd4;
    localparam logic [2:0] CFG_IDENT_LENGTH    = 3'd5;

    // Decoder phase.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_IDENT,
        PH_PALETTE,
        PH_HEADER,
        PH_VALUE,
        PH_DONE
    } phase_t;

    // Request into the row wrap divider.
    typedef struct packed {
        logic                  start;
        logic [SUM_W-1:0]      dividend;
        logic [COORD_BITS-1:0] divisor;
    } div_req_t;

    // Status and result of the row wrap divider.
    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [QUOT_W-1:0]     quot;
        logic [COORD_BITS-1:0] rem;
    } div_rsp_t;

    // Pixel size with out-of-range codes folded to 1 or 4.
    function automatic logic [2:0] eff_bpp(input logic [2:0] raw);
        logic [2:0] r;
        begin
            if (raw == 3'd0)
            begin
                r = 3'd1;
            end
            else if (raw > 3'd4)
            begin
                r = 3'd4;
            end
            else
            begin
                r = raw;
            end
            return r;
        end
    endfunction

    // Swap the blue and red bytes when the pixel has three or more bytes.
    function automatic logic [31:0] swap_rb(input logic [31:0] v, input logic [2:0] bpp);
        logic [31:0] r;
        begin
            if (bpp < 3'd3)
            begin
                r = v;
            end
            else
            begin
                r = {v[31:24], v[7:0], v[15:8], v[23:16]};
            end
            return r;
        end
    endfunction

endpackage

>>> rtl/tga_pixel_stream_decoder.sv
// ---------------------------------------------------------------------------
// TGA pixel stream decoder
// Decodes the TGA byte stream after the file header into pixels and runs
// with their destination row and column in a top-down image.
// ---------------------------------------------------------------------------
//  channel   | dir | beat contents
//  s_axis    | in  | tdata: data_byte; tuser: start_of_image
//  m_axis    | out | tdata: chan0..chan3, dest_row, dest_col, run_length;
//            |     | tuser: image_done
//  cfg       | in  | one register write per cycle with cfg_we high
//
// One input beat per cycle; a pixel result leaves in the cycle after the beat
// that completes it, the colormap lookup being a registered memory read.
// A run that wraps past two or more row ends stalls input while the row
// wrap divider finds the new row and column.
// Reset clears all control state; the colormap holds garbage until loaded.
// Input stalls only for that divider or when the output register is full.
// ---------------------------------------------------------------------------
module tga_pixel_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_of_image
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [7:0] chan0, [15:8] chan1, [23:16] chan2,
                                   // [31:24] chan3, [47:32] dest_row,
                                   // [63:48] dest_col, [71:64] run_length
    output logic        m_tuser,   // [0] image_done
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CB = tga_psd_pkg::COORD_BITS;
    localparam int TW = tga_psd_pkg::TOTAL_W;
    localparam int SW = tga_psd_pkg::SUM_W;
    localparam int AW = tga_psd_pkg::PAL_AW;

    // Configuration registers.
    logic [1:0]  kind_reg;
    logic [2:0]  bpp_cfg_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [15:0] pal_entries_reg;
    logic [7:0]  ident_len_reg;
    logic [TW-1:0] total;

    // Decoder state.
    tga_psd_pkg::phase_t phase_reg, phase_next, ph0;
    logic [7:0]    ident_cnt_reg, ident_cnt_next, ident_b;
    logic [1:0]    k_reg, k_next, k_b;
    logic [15:0]   entry_reg, entry_next, entry_b;
    logic [31:0]   asm_reg, asm_next, asm_b;
    logic [7:0]    pkt_rem_reg, pkt_rem_next, pkt_rem_b;
    logic          pkt_run_reg, pkt_run_next, pkt_run_b;
    logic [CB-1:0] col_reg, col_next, col_b;
    logic [CB-1:0] row_reg, row_next, row_b;
    logic [TW-1:0] left_reg, left_next, left_b;

    // Output register.
    logic          out_valid_reg;
    logic [31:0]   out_px_reg;
    logic          out_cmap_reg;
    logic          out_zero_reg;
    logic [CB-1:0] out_row_reg;
    logic [CB-1:0] out_col_reg;
    logic [7:0]    out_len_reg;
    logic          out_done_reg;

    // Colormap memory.
    logic [31:0]   pal_mem [tga_psd_pkg::PALETTE_DEPTH];
    logic [31:0]   pal_q_reg;
    logic          pal_we;
    logic [31:0]   pal_wdata;

    // Working signals.
    logic          accept;
    logic [2:0]    bpp;
    logic [CB-1:0] w;
    logic [CB-1:0] h;
    logic          empty;
    logic          is_cmap;
    logic          is_rle;
    tga_psd_pkg::phase_t pix_phase;
    logic [8:0]    ident_inc;
    logic [31:0]   asm_v;
    logic          ident_end;
    logic          pal_end;
    logic          emit;
    logic          emit_last;
    logic          no_left;
    logic          run_v;
    logic [7:0]    rem_v;
    logic [7:0]    n;
    logic [SW-1:0] s_sum;
    logic [SW-1:0] s_diff;
    logic [31:0]   emit_px;
    logic          idx_beyond;
    logic [31:0]   px;
    tga_psd_pkg::div_req_t div_req;
    tga_psd_pkg::div_rsp_t div_rsp;

    assign accept  = s_tvalid && s_tready;
    assign s_tready = !div_rsp.busy && !div_rsp.done && (!out_valid_reg || m_tready);

    assign bpp     = tga_psd_pkg::eff_bpp(bpp_cfg_reg);
    assign w       = width_reg[CB-1:0];
    assign h       = height_reg[CB-1:0];
    assign empty   = (w == '0) || (h == '0);
    assign is_cmap = !kind_reg[0];
    assign is_rle  = kind_reg[1];
    assign pix_phase = is_rle ? tga_psd_pkg::PH_HEADER : tga_psd_pkg::PH_VALUE;

    // Pixel count of the image, from the live dimensions.
    assign total   = TW'(w) * TW'(h);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg        <= 2'd3;
            bpp_cfg_reg     <= 3'd4;
            width_reg       <= 16'd1;
            height_reg      <= 16'd1;
            pal_entries_reg <= 16'd0;
            ident_len_reg   <= 8'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tga_psd_pkg::CFG_IMAGE_KIND:      kind_reg        <= cfg_data[1:0];
                    tga_psd_pkg::CFG_BYTES_PER_PIXEL: bpp_cfg_reg     <= cfg_data[2:0];
                    tga_psd_pkg::CFG_IMAGE_WIDTH:     width_reg       <= cfg_data;
                    tga_psd_pkg::CFG_IMAGE_HEIGHT:    height_reg      <= cfg_data;
                    tga_psd_pkg::CFG_PALETTE_ENTRIES: pal_entries_reg <= cfg_data;
                    tga_psd_pkg::CFG_IDENT_LENGTH:    ident_len_reg   <= cfg_data[7:0];
                    default:                          ;
                endcase
            end
        end
    end

    // State as seen by this beat: a start beat restarts everything first.
    always_comb
    begin
        if (s_tuser)
        begin
            ident_b   = '0;
            k_b       = '0;
            entry_b   = '0;
            asm_b     = '0;
            pkt_rem_b = '0;
            pkt_run_b = 1'b0;
            col_b     = '0;
            row_b     = '0;
            left_b    = total;
            if (empty)
            begin
                ph0 = tga_psd_pkg::PH_DONE;
            end
            else if (ident_len_reg != 8'd0)
            begin
                ph0 = tga_psd_pkg::PH_IDENT;
            end
            else if (is_cmap && pal_entries_reg != 16'd0)
            begin
                ph0 = tga_psd_pkg::PH_PALETTE;
            end
            else
            begin
                ph0 = pix_phase;
            end
        end
        else
        begin
            ident_b   = ident_cnt_reg;
            k_b       = k_reg;
            entry_b   = entry_reg;
            asm_b     = asm_reg;
            pkt_rem_b = pkt_rem_reg;
            pkt_run_b = pkt_run_reg;
            col_b     = col_reg;
            row_b     = row_reg;
            left_b    = left_reg;
            ph0       = phase_reg;
        end
    end

    // Datapath: byte assembly, colormap writes, packet and position update.
    always_comb
    begin
        ident_cnt_next = ident_b;
        k_next         = k_b;
        entry_next     = entry_b;
        asm_next       = asm_b;
        pkt_rem_next   = pkt_rem_b;
        pkt_run_next   = pkt_run_b;
        col_next       = col_b;
        row_next       = row_b;
        left_next      = left_b;
        ident_inc      = {1'b0, ident_b} + 9'd1;
        asm_v          = asm_b | (32'(s_tdata) << {k_b, 3'b000});
        ident_end      = 1'b0;
        pal_end        = 1'b0;
        pal_we         = 1'b0;
        pal_wdata      = tga_psd_pkg::swap_rb(asm_v, bpp);
        emit           = 1'b0;
        emit_last      = 1'b0;
        no_left        = 1'b0;
        emit_px        = tga_psd_pkg::swap_rb(asm_v, bpp);
        run_v          = kind_reg[1] ? pkt_run_b : 1'b0;
        rem_v          = kind_reg[1] ? pkt_rem_b : 8'd0;
        n              = 8'd1;
        s_sum          = '0;
        s_diff         = '0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = w;
        idx_beyond     = {1'b0, s_tdata} >= 9'(tga_psd_pkg::PALETTE_DEPTH);

        case (ph0)
            tga_psd_pkg::PH_IDENT:
            begin
                if (ident_inc >= {1'b0, ident_len_reg})
                begin
                    ident_end  = 1'b1;
                    ident_cnt_next = '0;
                    k_next     = '0;
                    asm_next   = '0;
                    entry_next = '0;
                end
                else
                begin
                    ident_cnt_next = ident_inc[7:0];
                end
            end
            tga_psd_pkg::PH_PALETTE:
            begin
                if ({1'b0, k_b} + 3'd1 >= bpp)
                begin
                    pal_we     = {1'b0, entry_b} < 17'(tga_psd_pkg::PALETTE_DEPTH);
                    asm_next   = '0;
                    k_next     = '0;
                    entry_next = entry_b + 16'd1;
                    pal_end    = ({1'b0, entry_b} + 17'd1) >= {1'b0, pal_entries_reg};
                end
                else
                begin
                    k_next   = k_b + 2'd1;
                    asm_next = asm_v;
                end
            end
            tga_psd_pkg::PH_HEADER:
            begin
                pkt_run_next = s_tdata[7];
                pkt_rem_next = {1'b0, s_tdata[6:0]} + 8'd1;
                k_next       = '0;
                asm_next     = '0;
            end
            tga_psd_pkg::PH_VALUE:
            begin
                pkt_run_next = run_v;
                pkt_rem_next = rem_v;
                if (is_cmap || ({1'b0, k_b} + 3'd1 >= bpp))
                begin
                    if (left_b == '0)
                    begin
                        no_left = 1'b1;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                else
                begin
                    k_next   = k_b + 2'd1;
                    asm_next = asm_v;
                end
                if (emit)
                begin
                    // Pixel count of the result, clipped at the image end.
                    n = run_v ? rem_v : 8'd1;
                    if (n == 8'd0)
                    begin
                        n = 8'd1;
                    end
                    if (TW'(n) > left_b)
                    begin
                        n = left_b[7:0];
                    end
                    emit_last = TW'(n) == left_b;
                    left_next = left_b - TW'(n);
                    if (run_v)
                    begin
                        pkt_rem_next = 8'd0;
                    end
                    else if (rem_v != 8'd0)
                    begin
                        pkt_rem_next = rem_v - 8'd1;
                    end
                    k_next   = '0;
                    asm_next = '0;
                    // Advance the position; wraps over several rows go to the divider.
                    s_sum  = SW'(col_b) + SW'(n);
                    s_diff = s_sum - SW'(w);
                    if (!emit_last)
                    begin
                        if (s_sum < SW'(w))
                        begin
                            col_next = s_sum[CB-1:0];
                        end
                        else if (s_diff < SW'(w))
                        begin
                            col_next = s_diff[CB-1:0];
                            row_next = row_b + CB'(1);
                        end
                        else
                        begin
                            div_req.start    = accept;
                            div_req.dividend = s_sum;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Next phase.
    always_comb
    begin
        phase_next = ph0;
        case (ph0)
            tga_psd_pkg::PH_IDENT:
            begin
                if (ident_end)
                begin
                    if (is_cmap && pal_entries_reg != 16'd0)
                    begin
                        phase_next = tga_psd_pkg::PH_PALETTE;
                    end
                    else
                    begin
                        phase_next = pix_phase;
                    end
                end
            end
            tga_psd_pkg::PH_PALETTE:
            begin
                if (pal_end)
                begin
                    phase_next = pix_phase;
                end
            end
            tga_psd_pkg::PH_HEADER:
            begin
                phase_next = tga_psd_pkg::PH_VALUE;
            end
            tga_psd_pkg::PH_VALUE:
            begin
                if (no_left || (emit && emit_last))
                begin
                    phase_next = tga_psd_pkg::PH_DONE;
                end
                else if (emit)
                begin
                    if (is_rle && pkt_rem_next == 8'd0)
                    begin
                        phase_next = tga_psd_pkg::PH_HEADER;
                    end
                    else
                    begin
                        phase_next = tga_psd_pkg::PH_VALUE;
                    end
                end
            end
            default:
            begin
                phase_next = ph0;
            end
        endcase
    end

    // Decoder state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tga_psd_pkg::PH_IDLE;
            ident_cnt_reg <= '0;
            k_reg         <= '0;
            entry_reg     <= '0;
            asm_reg       <= '0;
            pkt_rem_reg   <= '0;
            pkt_run_reg   <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            ident_cnt_reg <= ident_cnt_next;
            k_reg         <= k_next;
            entry_reg     <= entry_next;
            asm_reg       <= asm_next;
            pkt_rem_reg   <= pkt_rem_next;
            pkt_run_reg   <= pkt_run_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            left_reg      <= left_next;
        end
        else if (div_rsp.done)
        begin
            row_reg <= row_reg + CB'(div_rsp.quot);
            col_reg <= div_rsp.rem;
        end
    end

    // Row wrap divider.
    tga_psd_wrap_div u_wrap_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Colormap: written while loading, read once per colormapped result.
    always_ff @(posedge clk)
    begin
        if (accept && pal_we)
        begin
            pal_mem[entry_b[AW-1:0]] <= pal_wdata;
        end
        if (accept && emit && is_cmap)
        begin
            pal_q_reg <= pal_mem[s_tdata[AW-1:0]];
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_px_reg   <= emit_px;
            out_cmap_reg <= is_cmap;
            out_zero_reg <= idx_beyond;
            out_row_reg  <= h - CB'(1) - row_b;
            out_col_reg  <= col_b;
            out_len_reg  <= n;
            out_done_reg <= emit_last;
        end
    end

    // Pixel value and channel masking by pixel size.
    always_comb
    begin
        if (out_cmap_reg)
        begin
            px = out_zero_reg ? 32'd0 : pal_q_reg;
        end
        else
        begin
            px = out_px_reg;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign m_tdata[7:0]   = px[7:0];
    assign m_tdata[15:8]  = (bpp >= 3'd2) ? px[15:8] : 8'd0;
    assign m_tdata[23:16] = (bpp >= 3'd3) ? px[23:16] : 8'd0;
    assign m_tdata[31:24] = (bpp >= 3'd4) ? px[31:24] : 8'd0;
    assign m_tdata[47:32] = 16'(out_row_reg);
    assign m_tdata[63:48] = 16'(out_col_reg);
    assign m_tdata[71:64] = out_len_reg;
    assign m_tuser        = out_done_reg;

`ifndef SYNTHESIS
    // No beat is taken while the divider is still working out the position.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.busy |-> !s_tready)
        else $error("input accepted while row wrap divider busy");

    // A result that finishes the image leaves no pixels behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg) |-> (left_reg == '0))
        else $error("image done flagged with pixels left");

    // Every result covers at least one pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_len_reg != 8'd0))
        else $error("result with zero run length");

    // Bytes outside an image change no pixel count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_tuser && (phase_reg == tga_psd_pkg::PH_DONE ||
                                phase_reg == tga_psd_pkg::PH_IDLE))
        |=> $stable(left_reg))
        else $error("pixel count moved outside an image");
`endif

endmodule

>>> rtl/tga_psd_wrap_div.sv
// ---------------------------------------------------------------------------
// TGA decoder row wrap divider
// Restoring divider, one quotient bit per cycle, that splits the column
// plus run length into rows advanced and the new column.
// ---------------------------------------------------------------------------
module tga_psd_wrap_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tga_psd_pkg::div_req_t req,
    output tga_psd_pkg::div_rsp_t rsp
);

    localparam int TW = tga_psd_pkg::COORD_BITS + tga_psd_pkg::QUOT_W;

    logic                                  busy_reg;
    logic                                  done_reg;
    logic [$clog2(tga_psd_pkg::QUOT_W)-1:0] step_reg;
    logic [tga_psd_pkg::SUM_W-1:0]         rem_reg;
    logic [tga_psd_pkg::QUOT_W-1:0]        quot_reg;
    logic [tga_psd_pkg::COORD_BITS-1:0]    div_reg;

    logic [TW-1:0] trial;
    logic [TW-1:0] rem_ext;
    logic          fits;

    // Shifted divisor for the current quotient bit.
    always_comb
    begin
        trial   = TW'(div_reg) << step_reg;
        rem_ext = TW'(rem_reg);
        fits    = rem_ext >= trial;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '1;
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.dividend;
            div_reg  <= req.divisor;
            quot_reg <= '0;
        end
        else if (busy_reg && fits)
        begin
            rem_reg            <= tga_psd_pkg::SUM_W'(rem_ext - trial);
            quot_reg[step_reg] <= 1'b1;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg[tga_psd_pkg::COORD_BITS-1:0];

endmodule
